[rtl/core/bf16mv_pkg.sv]
// Shared types and constants for the bfloat16 matrix-vector multiplier.
// Used by bf16mv_fpu and bf16_matrix_vector_multiply; depends on nothing.
package bf16mv_pkg;

  localparam logic [15:0] BF16_QNAN = 16'h7FC0;
  localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;

  // Operation handed to the multiply-add unit
  typedef struct packed {
    logic        go;
    logic [15:0] mat_elem;
    logic [15:0] vec_elem;
    logic [31:0] acc;
  } fpu_req_t;

  // Completion of one multiply-add
  typedef struct packed {
    logic        done;
    logic [31:0] sum;
  } fpu_rsp_t;

endpackage

[rtl/core/bf16mv_fpu.sv]
// Seven-stage bfloat16 multiply with fp32 round-to-nearest-even accumulate.
// Depends on bf16mv_pkg for the request and response structs.
module bf16mv_fpu (
  input  logic                clk,
  input  logic                rst_n,
  input  bf16mv_pkg::fpu_req_t req,
  output bf16mv_pkg::fpu_rsp_t rsp
);

  // Count leading zeros of a 16-bit value
  function automatic logic [4:0] lzc16(input logic [15:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd16;
    hit = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 5'(15 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Count leading zeros of a 27-bit value
  function automatic logic [4:0] lzc27(input logic [26:0] v);
    logic [4:0] n;
    logic       hit;
    n   = 5'd27;
    hit = 1'b0;
    for (int i = 26; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n   = 5'(26 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Round a value n * 2^(e-153), n normalised at bit 26, to fp32
  function automatic logic [31:0] round32(input logic s, input logic signed [10:0] e,
                                          input logic [26:0] n);
    logic [53:0]       sh;
    logic [26:0]       n2;
    logic              st;
    logic [7:0]        ef;
    logic signed [10:0] amt;
    logic [5:0]        amtc;
    logic              inc;
    logic [30:0]       mag;
    sh   = '0;
    n2   = n;
    st   = 1'b0;
    ef   = e[7:0];
    amt  = 11'sd1 - e;
    amtc = (amt > 11'sd28) ? 6'd28 : amt[5:0];
    if (e >= 11'sd255) begin
      return {s, 8'hFF, 23'd0};
    end
    if (e <= 11'sd0) begin
      sh = {n, 27'd0} >> amtc;
      n2 = sh[53:27];
      st = |sh[26:0];
      ef = 8'd0;
    end
    inc = n2[2] & (n2[1] | n2[0] | st | n2[3]);
    mag = {ef, n2[25:3]} + 31'(inc);
    return {s, mag};
  endfunction

  // Stage valids
  logic [6:0] v_r;

  // Stage 1: product of mantissas and special cases
  logic              p1_s_r, p1_nan_r, p1_inf_r;
  logic [15:0]       p1_m_r;
  logic signed [10:0] p1_e_r;
  // Stage 2: normalised product
  logic              p2_s_r, p2_nan_r, p2_inf_r, p2_zero_r;
  logic [26:0]       p2_n_r;
  logic signed [10:0] p2_e_r;
  // Stage 3: rounded fp32 product
  logic [31:0]       p3_prod_r;
  // Stage 4: aligned operands
  logic [26:0]       a4_r, b4_r;
  logic              a4_sub_r, a4_s_r, a4_zs_r, a4_nan_r, a4_inf_r, a4_is_r;
  logic [7:0]        a4_e_r;
  // Stage 5: raw sum
  logic [27:0]       s5_r;
  logic              s5_s_r, s5_zs_r, s5_nan_r, s5_inf_r, s5_is_r;
  logic [7:0]        s5_e_r;
  // Stage 6: normalised sum
  logic [26:0]       n6_r;
  logic signed [10:0] n6_e_r;
  logic              n6_s_r, n6_zs_r, n6_zero_r, n6_nan_r, n6_inf_r, n6_is_r;
  // Stage 7: result
  logic [31:0]       sum_r;

  // Advance valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[5:0], req.go};
    end
  end

  assign rsp.done = v_r[6];
  assign rsp.sum  = sum_r;

  // Stage 1: unpack bf16 operands and multiply mantissas
  logic [7:0] ea, eb;
  logic [7:0] ma, mb;
  logic       an, ai, az, bn, bi, bz;
  always_comb begin
    ea = req.mat_elem[14:7];
    eb = req.vec_elem[14:7];
    ma = {|ea, req.mat_elem[6:0]};
    mb = {|eb, req.vec_elem[6:0]};
    an = (ea == 8'hFF) && (req.mat_elem[6:0] != '0);
    ai = (ea == 8'hFF) && (req.mat_elem[6:0] == '0);
    az = (ea == 8'h00) && (req.mat_elem[6:0] == '0);
    bn = (eb == 8'hFF) && (req.vec_elem[6:0] != '0);
    bi = (eb == 8'hFF) && (req.vec_elem[6:0] == '0);
    bz = (eb == 8'h00) && (req.vec_elem[6:0] == '0);
  end

  always_ff @(posedge clk) begin
    p1_s_r   <= req.mat_elem[15] ^ req.vec_elem[15];
    p1_nan_r <= an | bn | (ai & bz) | (bi & az);
    p1_inf_r <= ai | bi;
    p1_m_r   <= ma * mb;
    p1_e_r   <= $signed({3'd0, (ea == 8'd0) ? 8'd1 : ea})
              + $signed({3'd0, (eb == 8'd0) ? 8'd1 : eb});
  end

  // Stage 2: normalise the exact product
  logic [4:0]  lz_p;
  logic [26:0] p_wide;
  always_comb begin
    lz_p   = lzc16(p1_m_r);
    p_wide = {p1_m_r, 11'd0} << lz_p;
  end

  always_ff @(posedge clk) begin
    p2_s_r    <= p1_s_r;
    p2_nan_r  <= p1_nan_r;
    p2_inf_r  <= p1_inf_r;
    p2_zero_r <= (p1_m_r == '0);
    p2_n_r    <= p_wide;
    p2_e_r    <= p1_e_r - 11'sd126 - $signed({6'd0, lz_p});
  end

  // Stage 3: round the product to fp32
  always_ff @(posedge clk) begin
    priority if (p2_nan_r) begin
      p3_prod_r <= bf16mv_pkg::FP32_QNAN;
    end else if (p2_inf_r) begin
      p3_prod_r <= {p2_s_r, 8'hFF, 23'd0};
    end else if (p2_zero_r) begin
      p3_prod_r <= {p2_s_r, 31'd0};
    end else begin
      p3_prod_r <= round32(p2_s_r, p2_e_r, p2_n_r);
    end
  end

  // Stage 4: order the operands by magnitude and align the smaller one
  logic [7:0]  xe, ye, xee, yee, el, es, dsh;
  logic [23:0] xm, ym, ml, ms;
  logic        xs, ys, xn, xi, yn, yi, swp;
  logic [53:0] ext;
  logic [5:0]  dc;
  always_comb begin
    xs  = req.acc[31];
    ys  = p3_prod_r[31];
    xe  = req.acc[30:23];
    ye  = p3_prod_r[30:23];
    xm  = {|xe, req.acc[22:0]};
    ym  = {|ye, p3_prod_r[22:0]};
    xee = (xe == 8'd0) ? 8'd1 : xe;
    yee = (ye == 8'd0) ? 8'd1 : ye;
    xn  = (xe == 8'hFF) && (req.acc[22:0] != '0);
    xi  = (xe == 8'hFF) && (req.acc[22:0] == '0);
    yn  = (ye == 8'hFF) && (p3_prod_r[22:0] != '0);
    yi  = (ye == 8'hFF) && (p3_prod_r[22:0] == '0);
    swp = {yee, ym} > {xee, xm};
    el  = swp ? yee : xee;
    es  = swp ? xee : yee;
    ml  = swp ? ym : xm;
    ms  = swp ? xm : ym;
    dsh = el - es;
    dc  = (dsh > 8'd28) ? 6'd28 : dsh[5:0];
    ext = {ms, 3'd0, 27'd0} >> dc;
  end

  always_ff @(posedge clk) begin
    a4_r     <= {ml, 3'd0};
    b4_r     <= {ext[53:28], ext[27] | (|ext[26:0])};
    a4_sub_r <= xs ^ ys;
    a4_s_r   <= swp ? ys : xs;
    a4_zs_r  <= xs & ys;
    a4_e_r   <= el;
    a4_nan_r <= xn | yn | (xi & yi & (xs ^ ys));
    a4_inf_r <= xi | yi;
    a4_is_r  <= xi ? xs : ys;
  end

  // Stage 5: add or subtract magnitudes
  always_ff @(posedge clk) begin
    s5_r     <= a4_sub_r ? ({1'b0, a4_r} - {1'b0, b4_r}) : ({1'b0, a4_r} + {1'b0, b4_r});
    s5_s_r   <= a4_s_r;
    s5_zs_r  <= a4_zs_r;
    s5_e_r   <= a4_e_r;
    s5_nan_r <= a4_nan_r;
    s5_inf_r <= a4_inf_r;
    s5_is_r  <= a4_is_r;
  end

  // Stage 6: normalise the sum
  logic [4:0] lz_s;
  always_comb begin
    lz_s = lzc27(s5_r[26:0]);
  end

  always_ff @(posedge clk) begin
    if (s5_r[27]) begin
      n6_r   <= {s5_r[27:2], s5_r[1] | s5_r[0]};
      n6_e_r <= $signed({3'd0, s5_e_r}) + 11'sd1;
    end else begin
      n6_r   <= s5_r[26:0] << lz_s;
      n6_e_r <= $signed({3'd0, s5_e_r}) - $signed({6'd0, lz_s});
    end
    n6_zero_r <= (s5_r == '0);
    n6_s_r    <= s5_s_r;
    n6_zs_r   <= s5_zs_r;
    n6_nan_r  <= s5_nan_r;
    n6_inf_r  <= s5_inf_r;
    n6_is_r   <= s5_is_r;
  end

  // Stage 7: round the sum to fp32
  always_ff @(posedge clk) begin
    priority if (n6_nan_r) begin
      sum_r <= bf16mv_pkg::FP32_QNAN;
    end else if (n6_inf_r) begin
      sum_r <= {n6_is_r, 8'hFF, 23'd0};
    end else if (n6_zero_r) begin
      sum_r <= {n6_zs_r, 31'd0};
    end else begin
      sum_r <= round32(n6_s_r, n6_e_r, n6_r);
    end
  end

endmodule

[rtl/core/bf16_matrix_vector_multiply.sv]
// Top level of the bfloat16 matrix-vector multiplier: vector memory, control, config.
// Depends on bf16mv_pkg and bf16mv_fpu.
//
// A vector element (in_cmd 0) is written to the vector memory in the cycle it is
// taken and busy stays low, so loads go at one per cycle. A matrix element
// (in_cmd 1) reads its vector entry from the memory and passes through the
// seven-stage multiply-add unit; the accumulator is written back before the next
// element is taken. At the end of a row the result is rounded to bfloat16 and
// shown on the out_ ports for one cycle with out_strobe. The receiver cannot stall.
// No clearing pass follows reset.
module bf16_matrix_vector_multiply #(
  parameter int K_MAX = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [15:0] in_element,
  output logic        out_strobe,
  output logic [15:0] out_row_index,
  output logic [15:0] out_dot_value,
  output logic        out_last_row,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = $clog2(K_MAX);
  localparam int KW = $clog2(K_MAX + 1);
  localparam int CW = (KW > 9) ? KW : 9;

  localparam logic [1:0] REG_K_LEN     = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [1:0] REG_ROW_BASE  = 2'd2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]    state_r;
  logic [8:0]    k_len_r;
  logic [15:0]   row_count_r, row_base_r;
  logic [AW-1:0] lpos_r, cpos_r;
  logic [15:0]   rpos_r;
  logic [31:0]   acc_r;
  logic [15:0]   vec_rd_r, elem_r;
  logic          row_end_r, go_r;
  logic          out_strobe_r, out_last_r;
  logic [15:0]   out_index_r, out_dot_r;
  logic [15:0]   vec_mem [K_MAX];

  bf16mv_pkg::fpu_req_t fpu_req;
  bf16mv_pkg::fpu_rsp_t fpu_rsp;

  logic          take, take_load, take_mat;
  logic [CW-1:0] keff;
  logic [AW-1:0] lpos_eff, lpos_nxt, cpos_eff;
  logic          row_end;
  logic [15:0]   rc;
  logic          last;
  logic [31:0]   rnd;
  logic [15:0]   narrow;

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign take       = start && !busy;
  assign take_load  = take && !in_cmd;
  assign take_mat   = take && in_cmd;

  // Effective lengths and positions
  always_comb begin
    if (k_len_r == 9'd0) begin
      keff = CW'(1);
    end else if (CW'(k_len_r) > CW'(K_MAX)) begin
      keff = CW'(K_MAX);
    end else begin
      keff = CW'(k_len_r);
    end
    lpos_eff = (CW'(lpos_r) < keff) ? lpos_r : '0;
    lpos_nxt = ((CW'(lpos_eff) + CW'(1)) >= keff) ? '0 : lpos_eff + AW'(1);
    cpos_eff = (CW'(cpos_r) < keff) ? cpos_r : AW'(keff - CW'(1));
    row_end  = (CW'(cpos_eff) + CW'(1)) >= keff;
    rc       = (row_count_r == 16'd0) ? 16'd1 : row_count_r;
    last     = ({1'b0, rpos_r} + 17'd1) >= {1'b0, rc};
  end

  // Round the accumulator to bfloat16
  always_comb begin
    rnd = acc_r + 32'h0000_7FFF + {31'd0, acc_r[16]};
    if ((acc_r[30:23] == 8'hFF) && (acc_r[22:0] != '0)) begin
      narrow = bf16mv_pkg::BF16_QNAN;
    end else begin
      narrow = rnd[31:16];
    end
  end

  // Vector memory: write on a load, registered read on a matrix element
  always_ff @(posedge clk) begin
    if (take_load) begin
      vec_mem[lpos_eff] <= in_element;
    end
    if (take_mat) begin
      vec_rd_r <= vec_mem[cpos_eff];
    end
  end

  // Hold the matrix element and row end flag for the multiply-add
  always_ff @(posedge clk) begin
    if (take_mat) begin
      elem_r    <= in_element;
      row_end_r <= row_end;
    end
  end

  assign fpu_req.go       = go_r;
  assign fpu_req.mat_elem = elem_r;
  assign fpu_req.vec_elem = vec_rd_r;
  assign fpu_req.acc      = acc_r;

  bf16mv_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (fpu_req),
    .rsp   (fpu_rsp)
  );

  // Configuration transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_len_r     <= 9'd256;
      row_count_r <= 16'd1;
      row_base_r  <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_K_LEN:     k_len_r     <= cfg_data[8:0];
        REG_ROW_COUNT: row_count_r <= cfg_data;
        REG_ROW_BASE:  row_base_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, positions, accumulator and result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      lpos_r       <= '0;
      cpos_r       <= '0;
      rpos_r       <= '0;
      acc_r        <= '0;
      go_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      go_r         <= 1'b0;
      out_strobe_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (take_load) begin
            lpos_r <= lpos_nxt;
          end
          if (take_mat) begin
            cpos_r  <= row_end ? '0 : cpos_eff + AW'(1);
            go_r    <= 1'b1;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (fpu_rsp.done) begin
            acc_r   <= fpu_rsp.sum;
            state_r <= row_end_r ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          out_strobe_r <= 1'b1;
          rpos_r       <= last ? 16'd0 : rpos_r + 16'd1;
          acc_r        <= '0;
          state_r      <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT) begin
      out_index_r <= row_base_r + rpos_r;
      out_dot_r   <= narrow;
      out_last_r  <= last;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_row_index = out_index_r;
  assign out_dot_value = out_dot_r;
  assign out_last_row  = out_last_r;

endmodule

[rtl/core/bf16mv_checker.sv]
// Port-level checks for bf16_matrix_vector_multiply, bound to the top level.
// Depends on nothing but the top level's ports.
module bf16mv_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_cmd,
  input logic out_strobe
);

  // A result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("out_strobe held for two cycles");

  // A matrix element transfer makes the block busy
  a_mat_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd) |=> busy) else $error("busy not raised after matrix transfer");

  // A vector load keeps the block free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_cmd) |=> !busy) else $error("busy raised after vector load");

  // A result appears only once the row is finished
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result shown while busy");

  // Reset leaves the block quiet
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_strobe)) else $error("activity after reset");

endmodule

bind bf16_matrix_vector_multiply bf16mv_checker u_bf16mv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_cmd     (in_cmd),
  .out_strobe (out_strobe)
);
